FILE: rtl/core/ttn_pkg.sv
// shared constants and the divider step for the tick to nanosecond converter
package ttn_pkg;

    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned TICK_W    = 64;
    localparam int unsigned NS_W      = 64;
    localparam int unsigned SCALE_W   = 30;
    localparam int unsigned PROD_W    = FREQ_W + SCALE_W;
    localparam int unsigned DIV1_STEPS = TICK_W;
    localparam int unsigned DIV2_STEPS = SCALE_W;
    localparam int unsigned MUL_STAGES = 2;
    localparam int unsigned LATENCY    = 1 + DIV1_STEPS + MUL_STAGES + DIV2_STEPS + 1;

    localparam logic [SCALE_W-1:0] NS_PER_SEC    = SCALE_W'(1000000000);
    localparam logic [FREQ_W-1:0]  FREQ_RESET_HZ = FREQ_W'(19200000);

    typedef struct packed {
        logic              qbit;
        logic [FREQ_W-1:0] rem;
    } t_step;

    // one restoring division step: shift in a dividend bit, subtract if it fits
    function automatic t_step div_step(input logic [FREQ_W-1:0] rem,
                                       input logic              inbit,
                                       input logic [FREQ_W-1:0] divisor);
        logic [FREQ_W:0] trial;
        logic [FREQ_W:0] diff;
        t_step           res;
        trial = {rem, inbit};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            res.qbit = 1'b1;
            res.rem  = diff[FREQ_W-1:0];
        end else begin
            res.qbit = 1'b0;
            res.rem  = trial[FREQ_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/ttn_mul.sv
// two-stage scaling by one billion of the whole seconds and the remainder
module ttn_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ttn_pkg::TICK_W-1:0]  i_whole,
    input  logic [ttn_pkg::FREQ_W-1:0]  i_rem,
    output logic                        o_valid,
    output logic [ttn_pkg::NS_W-1:0]    o_base,
    output logic [ttn_pkg::PROD_W-1:0]  o_prod
);
    import ttn_pkg::*;

    logic                r_a_v;
    logic [PROD_W-1:0]   r_lo;
    logic [PROD_W-1:0]   r_hi;
    logic [PROD_W-1:0]   r_prod_a;
    logic                r_b_v;
    logic [NS_W-1:0]     r_base;
    logic [PROD_W-1:0]   r_prod_b;
    logic [NS_W-1:0]     n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= i_whole[31:0] * NS_PER_SEC;
        r_hi     <= i_whole[63:32] * NS_PER_SEC;
        r_prod_a <= i_rem * NS_PER_SEC;
        r_base   <= n_base;
        r_prod_b <= r_prod_a;
    end

    // high half only contributes its low 32 bits modulo 2^64
    assign n_base = NS_W'(r_lo) + {r_hi[31:0], 32'b0};

    assign o_valid = r_b_v;
    assign o_base  = r_base;
    assign o_prod  = r_prod_b;

endmodule

FILE: rtl/core/ticks_to_nanoseconds_unit.sv
// tick count to nanosecond converter, fully pipelined restoring dividers
//
// channel  | handshake                     | payload
// input    | start, busy                   | i_tick_count[63:0]
// result   | o_valid (strobe)              | o_nanoseconds[63:0]
// config   | i_cfg_valid, o_cfg_ready      | i_cfg_data[31:0]
//
// one beat enters every cycle; each result strobe follows its start through the stages
// (input register, 64 quotient steps, 2 multiply stages, 30 fraction steps,
// output register)
// reset clears all valid bits and loads 19200000 into the frequency register
// the pipeline never stalls: busy stays low and config is always ready
module ticks_to_nanoseconds_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ttn_pkg::TICK_W-1:0]  i_tick_count,
    output logic                        o_valid,
    output logic [ttn_pkg::NS_W-1:0]    o_nanoseconds,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ttn_pkg::FREQ_W-1:0]  i_cfg_data
);
    import ttn_pkg::*;

    logic [FREQ_W-1:0]  r_freq;

    logic               r_d1_v   [0:DIV1_STEPS];
    logic [FREQ_W-1:0]  r_d1_rem [0:DIV1_STEPS];
    logic [TICK_W-1:0]  r_d1_dq  [0:DIV1_STEPS];
    t_step              d1_step  [1:DIV1_STEPS];

    logic               m_v;
    logic [NS_W-1:0]    m_base;
    logic [PROD_W-1:0]  m_prod;

    logic               r_d2_v    [1:DIV2_STEPS];
    logic [FREQ_W-1:0]  r_d2_rem  [1:DIV2_STEPS];
    logic [SCALE_W-1:0] r_d2_dq   [1:DIV2_STEPS];
    logic [NS_W-1:0]    r_d2_base [1:DIV2_STEPS];
    logic [FREQ_W-1:0]  d2_rem_in [1:DIV2_STEPS];
    logic [SCALE_W-1:0] d2_dq_in  [1:DIV2_STEPS];
    t_step              d2_step   [1:DIV2_STEPS];

    logic               r_out_v;
    logic [NS_W-1:0]    r_out_ns;
    logic [NS_W-1:0]    n_out_ns;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET_HZ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_freq <= i_cfg_data;
        end
    end

    // quotient and remainder of ticks by frequency, one bit per stage
    always_comb begin
        for (int i = 1; i <= DIV1_STEPS; i++) begin
            d1_step[i] = div_step(r_d1_rem[i-1], r_d1_dq[i-1][TICK_W-1], r_freq);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_rem[0] <= '0;
        r_d1_dq[0]  <= i_tick_count;
        for (int i = 1; i <= DIV1_STEPS; i++) begin
            r_d1_rem[i] <= d1_step[i].rem;
            r_d1_dq[i]  <= {r_d1_dq[i-1][TICK_W-2:0], d1_step[i].qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV1_STEPS; i++) begin
                r_d1_v[i] <= 1'b0;
            end
        end else begin
            r_d1_v[0] <= start && !busy;
            for (int i = 1; i <= DIV1_STEPS; i++) begin
                r_d1_v[i] <= r_d1_v[i-1];
            end
        end
    end

    ttn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d1_v[DIV1_STEPS]),
        .i_whole (r_d1_dq[DIV1_STEPS]),
        .i_rem   (r_d1_rem[DIV1_STEPS]),
        .o_valid (m_v),
        .o_base  (m_base),
        .o_prod  (m_prod)
    );

    // fraction: product fits 30 quotient bits, so the top 32 bits seed the remainder
    always_comb begin
        d2_rem_in[1] = m_prod[PROD_W-1:SCALE_W];
        d2_dq_in[1]  = m_prod[SCALE_W-1:0];
        for (int j = 2; j <= DIV2_STEPS; j++) begin
            d2_rem_in[j] = r_d2_rem[j-1];
            d2_dq_in[j]  = r_d2_dq[j-1];
        end
        for (int j = 1; j <= DIV2_STEPS; j++) begin
            d2_step[j] = div_step(d2_rem_in[j], d2_dq_in[j][SCALE_W-1], r_freq);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2_base[1] <= m_base;
        for (int j = 2; j <= DIV2_STEPS; j++) begin
            r_d2_base[j] <= r_d2_base[j-1];
        end
        for (int j = 1; j <= DIV2_STEPS; j++) begin
            r_d2_rem[j] <= d2_step[j].rem;
            r_d2_dq[j]  <= {d2_dq_in[j][SCALE_W-2:0], d2_step[j].qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= DIV2_STEPS; j++) begin
                r_d2_v[j] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_d2_v[1] <= m_v;
            for (int j = 2; j <= DIV2_STEPS; j++) begin
                r_d2_v[j] <= r_d2_v[j-1];
            end
            r_out_v <= r_d2_v[DIV2_STEPS];
        end
    end

    // zero divisor answers all ones
    always_comb begin
        if (r_freq == '0) begin
            n_out_ns = '1;
        end else begin
            n_out_ns = r_d2_base[DIV2_STEPS] + NS_W'(r_d2_dq[DIV2_STEPS]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ns <= n_out_ns;
    end

    assign o_valid       = r_out_v;
    assign o_nanoseconds = r_out_ns;

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted beat did not produce a result");

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_out_v) |-> 1'b0)
        else $error("result strobe without an output stage beat");

    a_zero_freq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d2_v[DIV2_STEPS] && r_freq == '0) |=> (o_nanoseconds == '1))
        else $error("zero frequency did not saturate");

    a_frac_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_v && r_freq != '0) |-> (m_prod[PROD_W-1:SCALE_W] < r_freq))
        else $error("fraction dividend overflows its quotient width");
`endif

endmodule
